[sv/ihc_pkg.sv]
// ----------------------------------------------------------------------------
// ihc_pkg
// Shared types and constants for the IPv4 receive header check.
// ----------------------------------------------------------------------------
package ihc_pkg;

  localparam int unsigned AddrWidth = 3;
  localparam int unsigned DataWidth = 32;

  localparam logic [AddrWidth-1:0] ADDR_LOCAL_ADDRESS = 3'd0;

  localparam logic KIND_STATUS  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_VERSION   = 3'd1;
  localparam logic [2:0] ST_HDR_LEN   = 3'd2;
  localparam logic [2:0] ST_TTL       = 3'd3;
  localparam logic [2:0] ST_CHECKSUM  = 3'd4;
  localparam logic [2:0] ST_DEST      = 3'd5;
  localparam logic [2:0] ST_TRUNCATED = 3'd6;

  localparam logic [3:0]  IP_VERSION    = 4'd4;
  localparam logic [3:0]  MIN_IHL       = 4'd5;
  localparam logic [15:0] TTL_INDEX     = 16'd8;
  localparam logic [13:0] DEST_WORD     = 14'd4;
  localparam logic [15:0] COUNT_MAX     = 16'hffff;
  localparam logic [15:0] SUM_GOOD      = 16'hffff;
  localparam logic [31:0] BROADCAST     = 32'hffffffff;

  typedef struct packed {
    logic       kind;
    logic [2:0] status;
    logic [7:0] payload_byte;
    logic       end_of_packet;
  } result_t;

endpackage

[sv/ihc_cfg.sv]
// ----------------------------------------------------------------------------
// ihc_cfg
// APB register file holding the local IPv4 address.
// ----------------------------------------------------------------------------
module ihc_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ihc_pkg::AddrWidth-1:0]    paddr,
  input  logic [ihc_pkg::DataWidth-1:0]    pwdata,
  output logic [ihc_pkg::DataWidth-1:0]    prdata,
  output logic                             pready,
  output logic [31:0]                      local_address
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready &&
                  (paddr == ihc_pkg::ADDR_LOCAL_ADDRESS);

  always_ff @(posedge clk) begin
    if (rst) begin
      local_address <= 32'd0;
    end else if (wr_en) begin
      local_address <= pwdata;
    end
  end

  always_comb begin
    if (paddr == ihc_pkg::ADDR_LOCAL_ADDRESS) begin
      prdata = local_address;
    end else begin
      prdata = '0;
    end
  end

endmodule

[sv/ihc_core.sv]
// ----------------------------------------------------------------------------
// ihc_core
// Input register, per-byte header check and result register with stall.
// ----------------------------------------------------------------------------
module ihc_core (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         local_address,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output ihc_pkg::result_t    result
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DISCARD = 2'd2
  } phase_t;

  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              s1_last;

  phase_t            phase, phase_next;
  logic [15:0]       byte_count, byte_count_next;
  logic [3:0]        header_words, header_words_next;
  logic [7:0]        high_byte_hold, high_byte_hold_next;
  logic [15:0]       sum_accumulator, sum_accumulator_next;
  logic              ttl_was_zero, ttl_was_zero_next;
  logic [31:0]       destination_seen, destination_seen_next;

  logic              advance;
  logic              fire;
  logic              has_result;
  ihc_pkg::result_t  res;

  logic [3:0]        ver;
  logic [3:0]        ihl;
  logic [5:0]        hdr_end;
  logic [16:0]       sum_wide;
  logic [2:0]        verdict;

  assign advance  = !out_valid || !out_stall;
  assign fire     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  assign ver = s1_byte[7:4];
  assign ihl = s1_byte[3:0];

  always_comb begin
    phase_next            = phase;
    byte_count_next       = (byte_count != ihc_pkg::COUNT_MAX) ? byte_count + 16'd1
                                                               : byte_count;
    header_words_next     = header_words;
    high_byte_hold_next   = high_byte_hold;
    sum_accumulator_next  = sum_accumulator;
    ttl_was_zero_next     = ttl_was_zero;
    destination_seen_next = destination_seen;
    has_result            = 1'b0;
    res                   = '0;
    hdr_end               = '0;
    sum_wide              = '0;
    verdict               = ihc_pkg::ST_OK;

    case (phase)
      PH_HEADER: begin
        if (byte_count == 16'd0 && ver != ihc_pkg::IP_VERSION) begin
          has_result        = 1'b1;
          res.kind          = ihc_pkg::KIND_STATUS;
          res.status        = ihc_pkg::ST_VERSION;
          res.end_of_packet = 1'b1;
          phase_next        = PH_DISCARD;
        end else if (byte_count == 16'd0 && ihl < ihc_pkg::MIN_IHL) begin
          has_result        = 1'b1;
          res.kind          = ihc_pkg::KIND_STATUS;
          res.status        = ihc_pkg::ST_HDR_LEN;
          res.end_of_packet = 1'b1;
          phase_next        = PH_DISCARD;
        end else begin
          if (byte_count == 16'd0) begin
            header_words_next = ihl;
          end
          hdr_end = {header_words_next, 2'b00} - 6'd1;
          if (byte_count == ihc_pkg::TTL_INDEX && s1_byte == 8'd0) begin
            ttl_was_zero_next = 1'b1;
          end
          if (byte_count[15:2] == ihc_pkg::DEST_WORD) begin
            destination_seen_next = {destination_seen[23:0], s1_byte};
          end
          if (!byte_count[0]) begin
            high_byte_hold_next = s1_byte;
          end else begin
            sum_wide             = {1'b0, sum_accumulator} + {1'b0, high_byte_hold, s1_byte};
            sum_accumulator_next = sum_wide[15:0] + {15'd0, sum_wide[16]};
          end
          if (byte_count == {10'd0, hdr_end}) begin
            if (ttl_was_zero_next) begin
              verdict = ihc_pkg::ST_TTL;
            end else if (sum_accumulator_next != ihc_pkg::SUM_GOOD) begin
              verdict = ihc_pkg::ST_CHECKSUM;
            end else if (destination_seen_next != local_address &&
                         destination_seen_next != ihc_pkg::BROADCAST) begin
              verdict = ihc_pkg::ST_DEST;
            end
            has_result = 1'b1;
            res.kind   = ihc_pkg::KIND_STATUS;
            res.status = verdict;
            if (verdict != ihc_pkg::ST_OK) begin
              res.end_of_packet = 1'b1;
              phase_next        = PH_DISCARD;
            end else begin
              res.end_of_packet = s1_last;
              phase_next        = PH_PAYLOAD;
            end
          end else if (s1_last) begin
            has_result        = 1'b1;
            res.kind          = ihc_pkg::KIND_STATUS;
            res.status        = ihc_pkg::ST_TRUNCATED;
            res.end_of_packet = 1'b1;
          end
        end
      end
      PH_PAYLOAD: begin
        has_result        = 1'b1;
        res.kind          = ihc_pkg::KIND_PAYLOAD;
        res.payload_byte  = s1_byte;
        res.end_of_packet = s1_last;
      end
      default: begin
        has_result = 1'b0;
      end
    endcase

    if (s1_last) begin
      phase_next            = PH_HEADER;
      byte_count_next       = 16'd0;
      header_words_next     = 4'd0;
      high_byte_hold_next   = 8'd0;
      sum_accumulator_next  = 16'd0;
      ttl_was_zero_next     = 1'b0;
      destination_seen_next = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      byte_count       <= 16'd0;
      header_words     <= 4'd0;
      high_byte_hold   <= 8'd0;
      sum_accumulator  <= 16'd0;
      ttl_was_zero     <= 1'b0;
      destination_seen <= 32'd0;
    end else if (fire) begin
      phase            <= phase_next;
      byte_count       <= byte_count_next;
      header_words     <= header_words_next;
      high_byte_hold   <= high_byte_hold_next;
      sum_accumulator  <= sum_accumulator_next;
      ttl_was_zero     <= ttl_was_zero_next;
      destination_seen <= destination_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && has_result;
    end
    if (advance && fire) begin
      result <= res;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    fire && s1_last |=> byte_count == 16'd0 && phase == PH_HEADER)
    else $error("packet state not cleared after last beat");

  a_payload_after_header: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> byte_count >= 16'd20)
    else $error("payload phase entered inside minimum header");

  a_payload_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.kind == ihc_pkg::KIND_PAYLOAD |-> result.status == ihc_pkg::ST_OK)
    else $error("payload beat carries a status");

  a_error_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.kind == ihc_pkg::KIND_STATUS && result.status != ihc_pkg::ST_OK
    |-> result.end_of_packet)
    else $error("error verdict without end of packet");

endmodule

[sv/ipv4_header_check.sv]
// ----------------------------------------------------------------------------
// ipv4_header_check
// Receive-side IPv4 header validation on a byte stream.
// ----------------------------------------------------------------------------
// Input channel: one packet byte per beat (data_byte, last_byte on the final
// byte) under in_valid / in_stall. Output channel: one result per beat under
// out_valid / out_stall: a status verdict (kind 0) per packet, then the
// payload bytes (kind 1) with the header stripped; end_of_packet marks the
// packet's final result. Bytes that give no result (header, discarded tail)
// are absorbed silently.
// Throughput: one byte per cycle while out_stall does not hold a waiting
// result; each byte passes the input register, one short check/update step
// and the result register.
// When out_stall holds a waiting result, the input register fills and then
// in_stall rises; nothing is dropped. Reset (rst, synchronous) empties both
// registers, returns the packet tracker to the start of a header and clears
// local_address to zero. local_address sits at APB byte address 0.
// ----------------------------------------------------------------------------
module ipv4_header_check (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ihc_pkg::AddrWidth-1:0]    paddr,
  input  logic [ihc_pkg::DataWidth-1:0]    pwdata,
  output logic [ihc_pkg::DataWidth-1:0]    prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       data_byte,
  input  logic                             last_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             kind,
  output logic [2:0]                       status,
  output logic [7:0]                       payload_byte,
  output logic                             end_of_packet
);

  logic [31:0]      local_address;
  ihc_pkg::result_t result;

  ihc_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .local_address (local_address)
  );

  ihc_core u_core (
    .clk           (clk),
    .rst           (rst),
    .local_address (local_address),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result        (result)
  );

  assign kind          = result.kind;
  assign status        = result.status;
  assign payload_byte  = result.payload_byte;
  assign end_of_packet = result.end_of_packet;

endmodule

[tb/ipv4_header_check_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipv4_header_check_tb
// Feeds IPv4 packets through the header check byte by byte. The packets are
// mostly well-formed headers with random content, plus zero TTL, bad checksum,
// foreign destination, truncated, bad version / length and noise packets. A
// local model of the checker predicts every verdict and payload beat. The
// sender works in random bursts, the receiver stalls in changing patterns, and
// the local address is rewritten between traffic phases.
// ----------------------------------------------------------------------------
module ipv4_header_check_tb;

  localparam int unsigned RUN_LIMIT   = 200000;
  localparam int unsigned SETTLE      = 6;
  localparam int unsigned PHASE_BYTES = 150;

  typedef enum logic [1:0] {RX_HEADER, RX_PAYLOAD, RX_DISCARD} rx_phase_t;
  typedef enum int {STALL_NONE, STALL_COIN, STALL_EVERY_THIRD, STALL_HEAVY} stall_mode_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } wire_beat_t;

  logic                          clk     = 1'b0;
  logic                          rst     = 1'b1;
  logic                          psel    = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite  = 1'b0;
  logic [ihc_pkg::AddrWidth-1:0] paddr   = '0;
  logic [ihc_pkg::DataWidth-1:0] pwdata  = '0;
  logic [ihc_pkg::DataWidth-1:0] prdata;
  logic                          pready;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  logic [7:0]                    data_byte = 8'h00;
  logic                          last_byte = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          kind;
  logic [2:0]                    status;
  logic [7:0]                    payload_byte;
  logic                          end_of_packet;

  wire_beat_t         wire_bytes[$];
  ihc_pkg::result_t   results_due[$];
  int unsigned        fail_count   = 0;
  int unsigned        cycle_count  = 0;
  int unsigned        bytes_queued = 0;
  int unsigned        burst_left   = 0;
  int unsigned        gap_left     = 0;
  int unsigned        stall_span   = 0;
  stall_mode_t        stall_mode   = STALL_NONE;

  // model state of the packet tracker
  logic [31:0] host_addr   = '0;
  logic [15:0] rx_pos      = '0;
  logic [3:0]  rx_words    = '0;
  logic [7:0]  rx_hold     = '0;
  logic [15:0] rx_sum      = '0;
  logic        rx_ttl_zero = 1'b0;
  logic [31:0] rx_dst      = '0;
  rx_phase_t   rx_phase    = RX_HEADER;

  ipv4_header_check DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void owe_result(input logic k, input logic [2:0] st,
                                     input logic [7:0] b, input logic eop);
    results_due.push_back('{k, st, b, eop});
  endfunction

  task automatic track_ipv4_byte(input logic [7:0] b, input logic last);
    logic [15:0] idx;
    logic [15:0] hdr_end;
    logic [16:0] s;
    logic [2:0]  verdict;
    logic        done;
    idx  = rx_pos;
    done = 1'b0;
    if (rx_pos != ihc_pkg::COUNT_MAX) rx_pos++;
    case (rx_phase)
      RX_HEADER: begin
        if (idx == 16'd0) begin
          if (b[7:4] != ihc_pkg::IP_VERSION) begin
            owe_result(ihc_pkg::KIND_STATUS, ihc_pkg::ST_VERSION, 8'h00, 1'b1);
            rx_phase = RX_DISCARD;
            done = 1'b1;
          end else if (b[3:0] < ihc_pkg::MIN_IHL) begin
            owe_result(ihc_pkg::KIND_STATUS, ihc_pkg::ST_HDR_LEN, 8'h00, 1'b1);
            rx_phase = RX_DISCARD;
            done = 1'b1;
          end else begin
            rx_words = b[3:0];
          end
        end
        if (!done) begin
          hdr_end = {10'd0, rx_words, 2'b00} - 16'd1;
          if (idx == ihc_pkg::TTL_INDEX && b == 8'h00) rx_ttl_zero = 1'b1;
          if (idx[15:2] == ihc_pkg::DEST_WORD) rx_dst = {rx_dst[23:0], b};
          if (!idx[0]) begin
            rx_hold = b;
          end else begin
            s = {1'b0, rx_sum} + {1'b0, rx_hold, b};
            rx_sum = s[15:0] + {15'd0, s[16]};
          end
          if (idx == hdr_end) begin
            if (rx_ttl_zero) verdict = ihc_pkg::ST_TTL;
            else if (rx_sum != ihc_pkg::SUM_GOOD) verdict = ihc_pkg::ST_CHECKSUM;
            else if (rx_dst != host_addr && rx_dst != ihc_pkg::BROADCAST)
              verdict = ihc_pkg::ST_DEST;
            else verdict = ihc_pkg::ST_OK;
            if (verdict == ihc_pkg::ST_OK) begin
              owe_result(ihc_pkg::KIND_STATUS, ihc_pkg::ST_OK, 8'h00, last);
              rx_phase = RX_PAYLOAD;
            end else begin
              owe_result(ihc_pkg::KIND_STATUS, verdict, 8'h00, 1'b1);
              rx_phase = RX_DISCARD;
            end
          end else if (last) begin
            owe_result(ihc_pkg::KIND_STATUS, ihc_pkg::ST_TRUNCATED, 8'h00, 1'b1);
          end
        end
      end
      RX_PAYLOAD: owe_result(ihc_pkg::KIND_PAYLOAD, ihc_pkg::ST_OK, b, last);
      default: ;
    endcase
    if (last) begin
      rx_pos      = '0;
      rx_words    = '0;
      rx_hold     = '0;
      rx_sum      = '0;
      rx_ttl_zero = 1'b0;
      rx_dst      = '0;
      rx_phase    = RX_HEADER;
    end
  endtask

  // build a header from byte 0, fix up TTL, destination and checksum, add payload, optionally cut short
  task automatic queue_datagram(input logic [7:0] first, input bit zero_ttl, input bit bad_sum,
                                input bit bad_dst, input int pay_len, input int cut);
    logic [7:0]  pkt[$];
    int          hlen;
    int          n;
    logic [16:0] s;
    logic [15:0] acc;
    logic [31:0] dst;
    hlen = (first[3:0] >= ihc_pkg::MIN_IHL) ? 4 * int'(first[3:0]) : 20;
    pkt.push_back(first);
    for (int i = 1; i < hlen; i++) pkt.push_back(8'($urandom));
    pkt[8] = zero_ttl ? 8'h00 : 8'($urandom_range(1, 255));
    if (bad_dst) begin
      dst = ($urandom_range(0, 1) == 1) ? host_addr ^ (32'd1 << $urandom_range(0, 31))
                                        : 32'($urandom);
      while (dst == host_addr || dst == ihc_pkg::BROADCAST) dst = $urandom;
    end else begin
      dst = ($urandom_range(0, 1) == 1) ? host_addr : ihc_pkg::BROADCAST;
    end
    pkt[16] = dst[31:24];
    pkt[17] = dst[23:16];
    pkt[18] = dst[15:8];
    pkt[19] = dst[7:0];
    pkt[10] = 8'h00;
    pkt[11] = 8'h00;
    acc = '0;
    for (int i = 0; i < hlen; i += 2) begin
      s = {1'b0, acc} + {1'b0, pkt[i], pkt[i+1]};
      acc = s[15:0] + {15'd0, s[16]};
    end
    acc = ~acc;
    if (bad_sum) acc ^= 16'($urandom_range(1, 65535));
    pkt[10] = acc[15:8];
    pkt[11] = acc[7:0];
    repeat (pay_len) pkt.push_back(8'($urandom));
    n = (cut > 0 && cut < pkt.size()) ? cut : pkt.size();
    for (int i = 0; i < n; i++) wire_bytes.push_back('{pkt[i], i == n - 1});
    bytes_queued += n;
  endtask

  task automatic queue_random_datagram();
    int         roll;
    int         ihl;
    int         pay;
    logic [3:0] ver;
    logic [7:0] first;
    roll  = $urandom_range(0, 99);
    ihl   = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 15) : 5;
    pay   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    first = {ihc_pkg::IP_VERSION, 4'(ihl)};
    if (roll < 50) begin
      queue_datagram(first, 0, 0, 0, pay, 0);
    end else if (roll < 58) begin
      queue_datagram(first, 1, $urandom_range(0, 1), $urandom_range(0, 1), pay, 0);
    end else if (roll < 66) begin
      queue_datagram(first, 0, 1, $urandom_range(0, 1), pay, 0);
    end else if (roll < 74) begin
      queue_datagram(first, 0, 0, 1, pay, 0);
    end else if (roll < 80) begin
      queue_datagram(first, $urandom_range(0, 1), 0, 0, 0, $urandom_range(1, 4 * ihl - 1));
    end else if (roll < 86) begin
      ver = 4'($urandom);
      if (ver == ihc_pkg::IP_VERSION) ver = ~ver;
      queue_datagram({ver, 4'($urandom)}, 0, 0, 0, $urandom_range(0, 4), 0);
    end else if (roll < 90) begin
      queue_datagram({ihc_pkg::IP_VERSION, 4'($urandom_range(0, 4))}, 0, 0, 0,
                     $urandom_range(0, 4), $urandom_range(0, 25));
    end else if (roll < 96) begin
      queue_datagram(first, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                     pay, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4 * ihl + pay) : 0);
    end else begin
      queue_datagram(8'($urandom), $urandom_range(0, 1), $urandom_range(0, 1),
                     $urandom_range(0, 1), $urandom_range(0, 10), $urandom_range(1, 30));
    end
  endtask

  task automatic set_host_address(input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ihc_pkg::ADDR_LOCAL_ADDRESS;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    host_addr = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) begin
      $display("%0t: local_address readback expected %08h actual %08h", $time, value, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    while (wire_bytes.size() != 0 || in_valid || results_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // byte sender
  always @(posedge clk) begin : drive_bytes
    wire_beat_t beat;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_ipv4_byte(data_byte, last_byte);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0 || wire_bytes.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          beat = wire_bytes.pop_front();
          data_byte <= beat.value;
          last_byte <= beat.last;
          in_valid  <= 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end
      end
    end
  end

  // result receiver stall pattern
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_span = $urandom_range(8, 80);
    end else begin
      stall_span--;
    end
    case (stall_mode)
      STALL_NONE:        out_stall <= 1'b0;
      STALL_COIN:        out_stall <= ($urandom_range(0, 1) == 1);
      STALL_EVERY_THIRD: out_stall <= (stall_span % 3 == 0);
      default:           out_stall <= ($urandom_range(0, 4) != 0);
    endcase
  end

  always @(posedge clk) begin : check_results
    ihc_pkg::result_t got;
    ihc_pkg::result_t due;
    if (!rst && out_valid && !out_stall) begin
      got = {kind, status, payload_byte, end_of_packet};
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result kind=%0d status=%0d byte=%02h eop=%0d", $time,
                 got.kind, got.status, got.payload_byte, got.end_of_packet);
        fail_count++;
      end else begin
        due = results_due.pop_front();
        if (got !== due) begin
          $display({"%0t: expected kind=%0d status=%0d byte=%02h eop=%0d, ",
                    "actual kind=%0d status=%0d byte=%02h eop=%0d"},
                   $time, due.kind, due.status, due.payload_byte, due.end_of_packet,
                   got.kind, got.status, got.payload_byte, got.end_of_packet);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("[ipv4_header_check] ERROR");
      $finish;
    end
  end

  initial begin
    logic [31:0] host_settings[4];
    host_settings[0] = $urandom;
    host_settings[1] = ihc_pkg::BROADCAST;
    host_settings[2] = $urandom;
    host_settings[3] = 32'h0000_0000;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    set_host_address(32'h0000_0000);
    queue_datagram(8'h00, 0, 0, 0, 0, 1);
    queue_datagram(8'hf5, 0, 0, 0, 0, 2);
    queue_datagram(8'h44, 0, 0, 0, 0, 1);
    queue_datagram(8'h40, 0, 0, 0, 0, 2);
    queue_datagram(8'h45, 0, 0, 0, 0, 1);
    queue_datagram(8'h45, 0, 0, 0, 0, 0);
    wait_idle();
    foreach (host_settings[p]) begin
      set_host_address(host_settings[p]);
      bytes_queued = 0;
      while (bytes_queued < PHASE_BYTES) queue_random_datagram();
      wait_idle();
    end
    if (fail_count == 0) begin
      $display("[ipv4_header_check] OK");
    end else begin
      $display("[ipv4_header_check] ERROR");
    end
    $finish;
  end

endmodule
